// ===== src/bgd_pkg.sv =====
// bgd_pkg: shared types and constants of the button gesture detector
// no dependencies
`timescale 1ns / 1ps
package bgd_pkg;

    localparam int NUM_EVENTS   = 5;
    localparam int DEFAULT_LOG_DEPTH = 8;
    localparam logic [2:0] COUNT_MAX = 3'd7;

    localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [2:0] REG_PERS_MASK   = 3'd1;
    localparam logic [2:0] REG_PERS_DELAY  = 3'd2;
    localparam logic [2:0] REG_HOLD_MIN    = 3'd3;
    localparam logic [2:0] REG_TAP_MAX     = 3'd4;
    localparam logic [2:0] REG_DPRESS_MAX  = 3'd5;
    localparam logic [2:0] REG_DGAP_MAX    = 3'd6;

    localparam int EV_PRESS   = 0;
    localparam int EV_RELEASE = 1;
    localparam int EV_HOLD    = 2;
    localparam int EV_SINGLE  = 3;
    localparam int EV_DOUBLE  = 4;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        raw_level;
    } bgd_in_t;

    typedef struct packed {
        logic        press_event;
        logic        release_event;
        logic        hold_event;
        logic        single_tap_event;
        logic        double_tap_event;
        logic [31:0] event_time_ms;
    } bgd_out_t;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [4:0]  persistent_mask;
        logic [15:0] persistent_delay_ms;
        logic [15:0] hold_min_ms;
        logic [15:0] tap_max_ms;
        logic [15:0] double_press_max_ms;
        logic [15:0] double_gap_max_ms;
    } bgd_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_OUT
    } bgd_state_t;

endpackage

// ===== src/bgd_front.sv =====
// bgd_front: accepts polls and holds them in a two-entry queue
// depends on bgd_pkg
`timescale 1ns / 1ps
module bgd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    output logic             stall,
    input  bgd_pkg::bgd_in_t in_item,
    output logic             q_valid,
    output bgd_pkg::bgd_in_t q_item,
    input  logic             q_pop
);
    import bgd_pkg::*;

    bgd_in_t    mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign stall   = (cnt_reg == 2'd2);
    assign push    = valid && !stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push) else $error("push into full queue");
`endif
endmodule

// ===== src/bgd_back.sv =====
// bgd_back: debounce log, counters and gesture matching, one event per cycle
// depends on bgd_pkg
`timescale 1ns / 1ps
module bgd_back #(
    parameter int LOG_DEPTH = bgd_pkg::DEFAULT_LOG_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bgd_pkg::bgd_cfg_t cfg,
    input  logic              q_valid,
    input  bgd_pkg::bgd_in_t  q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output bgd_pkg::bgd_out_t out_item
);
    import bgd_pkg::*;

    bgd_state_t  state_reg, state_next;
    logic [2:0]  ev_reg;
    logic        log_level_reg [LOG_DEPTH];
    logic [31:0] log_stamp_reg [LOG_DEPTH];
    logic [2:0]  cnt_reg [NUM_EVENTS];
    logic [31:0] rep_reg [NUM_EVENTS];
    logic [NUM_EVENTS-1:0] hit_reg;
    logic [31:0] now_reg;
    logic        shift;
    logic        match;
    logic        gate;
    logic        pers;
    logic [2:0]  plen;
    logic        start;
    logic        last_ev;

    // debounce decision on the queue head
    assign shift = ((q_item.raw_level != log_level_reg[0]) &&
                    ((q_item.now_ms - log_stamp_reg[0]) >= {16'd0, cfg.debounce_ms}))
                   || (log_stamp_reg[0] == 32'd0);
    assign start   = (state_reg == ST_IDLE) && q_valid;
    assign last_ev = (ev_reg == 3'(NUM_EVENTS - 1));

    // entry k ok: level, min and max (k > 0 compares with newer entry)
    function automatic logic ent_ok(input logic lv, input logic [31:0] a,
                                    input logic [31:0] b, input logic newest,
                                    input logic want, input logic [31:0] mn,
                                    input logic [31:0] mx);
        logic ok;
        begin
            ok = (lv == want);
            if (newest)
            begin
                if ((a + mn) > b) ok = 1'b0;
            end
            else
            begin
                if ((a + mn) >= b) ok = 1'b0;
                if ((mx != 32'd0) && ((a + mx) <= b)) ok = 1'b0;
            end
            ent_ok = ok;
        end
    endfunction

    always_comb
    begin
        logic [31:0] hm, tm, dp, dg;
        hm = {16'd0, cfg.hold_min_ms};
        tm = {16'd0, cfg.tap_max_ms};
        dp = {16'd0, cfg.double_press_max_ms};
        dg = {16'd0, cfg.double_gap_max_ms};
        pers = cfg.persistent_mask[ev_reg];
        case (ev_reg)
            3'd0:
            begin
                plen  = 3'd2;
                match = ent_ok(log_level_reg[0], log_stamp_reg[0], now_reg, 1'b1,
                               1'b1, 32'd0, 32'd0)
                     && ent_ok(log_level_reg[1], log_stamp_reg[1], log_stamp_reg[0],
                               1'b0, 1'b0, 32'd0, 32'd0);
            end
            3'd1:
            begin
                plen  = 3'd2;
                match = ent_ok(log_level_reg[0], log_stamp_reg[0], now_reg, 1'b1,
                               1'b0, 32'd0, 32'd0)
                     && ent_ok(log_level_reg[1], log_stamp_reg[1], log_stamp_reg[0],
                               1'b0, 1'b1, 32'd0, 32'd0);
            end
            3'd2:
            begin
                plen  = 3'd2;
                match = ent_ok(log_level_reg[0], log_stamp_reg[0], now_reg, 1'b1,
                               1'b1, hm, 32'd0)
                     && ent_ok(log_level_reg[1], log_stamp_reg[1], log_stamp_reg[0],
                               1'b0, 1'b0, 32'd0, 32'd0);
            end
            3'd3:
            begin
                plen  = 3'd3;
                match = ent_ok(log_level_reg[0], log_stamp_reg[0], now_reg, 1'b1,
                               1'b0, 32'd0, 32'd0)
                     && ent_ok(log_level_reg[1], log_stamp_reg[1], log_stamp_reg[0],
                               1'b0, 1'b1, 32'd0, tm)
                     && ent_ok(log_level_reg[2], log_stamp_reg[2], log_stamp_reg[1],
                               1'b0, 1'b0, 32'd0, 32'd0);
            end
            3'd4:
            begin
                plen  = 3'd5;
                match = ent_ok(log_level_reg[0], log_stamp_reg[0], now_reg, 1'b1,
                               1'b0, 32'd0, 32'd0)
                     && ent_ok(log_level_reg[1], log_stamp_reg[1], log_stamp_reg[0],
                               1'b0, 1'b1, 32'd0, dp)
                     && ent_ok(log_level_reg[2], log_stamp_reg[2], log_stamp_reg[1],
                               1'b0, 1'b0, 32'd0, dg)
                     && ent_ok(log_level_reg[3], log_stamp_reg[3], log_stamp_reg[2],
                               1'b0, 1'b1, 32'd0, dp)
                     && ent_ok(log_level_reg[4], log_stamp_reg[4], log_stamp_reg[3],
                               1'b0, 1'b0, 32'd0, 32'd0);
            end
            default:
            begin
                plen  = 3'd7;
                match = 1'b0;
            end
        endcase
        gate = (cnt_reg[ev_reg] >= plen) ||
               (pers && ((now_reg - rep_reg[ev_reg]) >= {16'd0, cfg.persistent_delay_ms}));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_EVAL;
            ST_EVAL: if (last_ev) state_next = ST_OUT;
            ST_OUT:  if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = start;
        out_valid = (state_reg == ST_OUT);
        out_item.press_event      = hit_reg[EV_PRESS];
        out_item.release_event    = hit_reg[EV_RELEASE];
        out_item.hold_event       = hit_reg[EV_HOLD];
        out_item.single_tap_event = hit_reg[EV_SINGLE];
        out_item.double_tap_event = hit_reg[EV_DOUBLE];
        out_item.event_time_ms    = now_reg;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            now_reg <= q_item.now_ms;
            hit_reg <= '0;
        end
        else if (state_reg == ST_EVAL)
        begin
            hit_reg[ev_reg] <= gate && match;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ev_reg    <= 3'd0;
            for (int i = 0; i < LOG_DEPTH; i++)
            begin
                log_level_reg[i] <= 1'b0;
                log_stamp_reg[i] <= 32'd0;
            end
            for (int i = 0; i < NUM_EVENTS; i++)
            begin
                cnt_reg[i] <= 3'd1;
                rep_reg[i] <= 32'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                ev_reg <= 3'd0;
                if (shift)
                begin
                    for (int i = LOG_DEPTH - 1; i > 0; i--)
                    begin
                        log_level_reg[i] <= log_level_reg[i-1];
                        log_stamp_reg[i] <= log_stamp_reg[i-1];
                    end
                    log_level_reg[0] <= q_item.raw_level;
                    log_stamp_reg[0] <= q_item.now_ms;
                    for (int i = 0; i < NUM_EVENTS; i++)
                    begin
                        if (cnt_reg[i] < COUNT_MAX) cnt_reg[i] <= cnt_reg[i] + 3'd1;
                    end
                end
            end
            else if (state_reg == ST_EVAL)
            begin
                ev_reg <= ev_reg + 3'd1;
                if (gate && match)
                begin
                    if ((cnt_reg[ev_reg] == 3'd0) && pers) rep_reg[ev_reg] <= now_reg;
                    cnt_reg[ev_reg] <= (ev_reg == 3'(EV_SINGLE)) ? 3'd1 : 3'd0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_eval_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> (ev_reg < 3'(NUM_EVENTS))) else $error("event index");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(hit_reg)))
        else $error("result changed under stall");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE)) else $error("pop while busy");
`endif
endmodule

// ===== src/button_gesture_detector.sv =====
// button gesture detector: a poll is dequeued, then its five events are checked in turn,
// then the result is shown; one poll at a time, so a new poll is taken only after
// the last result has been transferred, and any result stall holds the flow;
// the steps are set by the five-step event sequencer in the back end
// reset clears log and queue, sets the event counters to one and loads the register defaults
`timescale 1ns / 1ps
// top level: register file, input queue and matching back end
// depends on bgd_pkg, bgd_front, bgd_back
module button_gesture_detector #(
    parameter int LOG_DEPTH = bgd_pkg::DEFAULT_LOG_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  bgd_pkg::bgd_in_t  in_data,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output bgd_pkg::bgd_out_t out_data,
    // configuration writes
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_wdata
);
    import bgd_pkg::*;

    bgd_cfg_t cfg_reg;
    logic     q_valid;
    logic     q_pop;
    bgd_in_t  q_item;

    // register file, writes beyond index six are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms         <= 16'd10;
            cfg_reg.persistent_mask     <= 5'd0;
            cfg_reg.persistent_delay_ms <= 16'd50;
            cfg_reg.hold_min_ms         <= 16'd1000;
            cfg_reg.tap_max_ms          <= 16'd999;
            cfg_reg.double_press_max_ms <= 16'd1999;
            cfg_reg.double_gap_max_ms   <= 16'd250;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   cfg_reg.debounce_ms         <= cfg_wdata;
                REG_PERS_MASK:  cfg_reg.persistent_mask     <= cfg_wdata[4:0];
                REG_PERS_DELAY: cfg_reg.persistent_delay_ms <= cfg_wdata;
                REG_HOLD_MIN:   cfg_reg.hold_min_ms         <= cfg_wdata;
                REG_TAP_MAX:    cfg_reg.tap_max_ms          <= cfg_wdata;
                REG_DPRESS_MAX: cfg_reg.double_press_max_ms <= cfg_wdata;
                REG_DGAP_MAX:   cfg_reg.double_gap_max_ms   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front end: transfer acceptance and short queue
    bgd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (in_valid),
        .stall   (in_stall),
        .in_item (in_data),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    // back end: debounce log and gesture sequencer
    bgd_back #(.LOG_DEPTH(LOG_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_data)
    );

endmodule
